// ----- sv/configurable_table_crc_macros.svh -----
// Assertion macros shared by the CRC engine.
`ifndef CONFIGURABLE_TABLE_CRC_MACROS_SVH
`define CONFIGURABLE_TABLE_CRC_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ctc_pkg.sv -----
package ctc_pkg;

  localparam int unsigned CRC_W      = 32;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned WIDTH_W    = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_REFLECTED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POLYNOMIAL    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VALUE = 2'd3;

  localparam logic               RESET_REFLECTED     = 1'b1;
  localparam logic [WIDTH_W-1:0] RESET_CRC_WIDTH     = 6'd32;
  localparam logic [CRC_W-1:0]   RESET_POLYNOMIAL    = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0]   RESET_INITIAL_VALUE = 32'h0000_0000;

  localparam logic [WIDTH_W-1:0] MIN_CRC_WIDTH = 6'd8;
  localparam logic [WIDTH_W-1:0] MAX_CRC_WIDTH = 6'd32;

  typedef struct packed {
    logic             reflected;
    logic [CRC_W-1:0] polynomial;
    logic [CRC_W-1:0] poly_aligned;
    logic [CRC_W-1:0] initial_value;
    logic             bad;
  } ctc_cfg_t;

endpackage

// ----- sv/ctc_in_if.sv -----
interface ctc_in_if;
  logic                         valid;
  logic                         ready;
  logic [ctc_pkg::DATA_W-1:0]   data_byte;
  logic                         first_byte;
  logic                         last_byte;

  modport source(output valid, output data_byte, output first_byte, output last_byte,
                 input ready);
  modport sink(input valid, input data_byte, input first_byte, input last_byte,
               output ready);
endinterface

// ----- sv/ctc_out_if.sv -----
interface ctc_out_if;
  logic                       valid;
  logic                       ready;
  logic [ctc_pkg::CRC_W-1:0]  crc_value;
  logic                       config_error;

  modport source(output valid, output crc_value, output config_error, input ready);
  modport sink(input valid, input crc_value, input config_error, output ready);
endinterface

// ----- sv/configurable_table_crc.sv -----
// Byte-wise CRC engine with a run-time width of 8 to 32 bits, polynomial and bit order.
// One byte is taken per clock cycle, except that a block's last byte waits in the input
// register while an earlier result is still untaken; a byte passes the input register and
// is folded into the CRC register by an unrolled eight-step LFSR update, and on the last
// byte of a block the same update is loaded into the output register as the byte leaves
// the input register. The sustained rate of one byte per cycle is set by the loop from
// the CRC register through the byte update and back. A bad configuration leaves the CRC
// register untouched and flags config_error on the result.
module configurable_table_crc (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ctc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ctc_pkg::CFG_DATA_W-1:0]  cfg_data,
  ctc_in_if.sink                          data_in,
  ctc_out_if.source                       result
);
  import ctc_pkg::*;

  `include "configurable_table_crc_macros.svh"

  ctc_cfg_t          cfg;
  logic              s1_valid;
  logic [DATA_W-1:0] s1_data;
  logic              s1_first;
  logic              s1_last;
  logic              s1_fire;
  logic              in_fire;
  logic [CRC_W-1:0]  crc_register;
  logic [CRC_W-1:0]  crc_next;
  logic              out_valid;
  logic [CRC_W-1:0]  out_crc;
  logic              out_error;

  ctc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ctc_crc_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .update       (s1_fire),
    .data_byte    (s1_data),
    .first_byte   (s1_first),
    .crc_register (crc_register),
    .crc_next     (crc_next)
  );

  // A byte that ends no block never waits on the output side.
  assign s1_fire       = s1_valid && (!s1_last || !out_valid || result.ready);
  assign data_in.ready = !s1_valid || s1_fire;
  assign in_fire       = data_in.valid && data_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data  <= data_in.data_byte;
      s1_first <= data_in.first_byte;
      s1_last  <= data_in.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      out_crc   <= crc_next;
      out_error <= cfg.bad;
    end
  end

  assign result.valid        = out_valid;
  assign result.crc_value    = out_crc;
  assign result.config_error = out_error;

  `CTC_ASSERT_NEXT(a_bad_cfg_holds_crc, s1_fire && cfg.bad, crc_register == $past(crc_register), "CRC register changed under a bad configuration")
  `CTC_ASSERT_NEXT(a_last_gives_result, s1_fire && s1_last, result.valid && result.crc_value == $past(crc_next), "last byte did not produce its result")
  `CTC_ASSERT_NOW(a_empty_stage_ready, !s1_valid, data_in.ready, "input stage empty but not ready")
endmodule

// ----- sv/ctc_cfg_regs.sv -----
module ctc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [ctc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ctc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output ctc_pkg::ctc_cfg_t                 cfg
);
  import ctc_pkg::*;

  logic               reflected;
  logic [WIDTH_W-1:0] crc_width;
  logic [CRC_W-1:0]   polynomial;
  logic [CRC_W-1:0]   initial_value;
  logic [WIDTH_W-1:0] align_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      reflected     <= RESET_REFLECTED;
      crc_width     <= RESET_CRC_WIDTH;
      polynomial    <= RESET_POLYNOMIAL;
      initial_value <= RESET_INITIAL_VALUE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_REFLECTED:     reflected     <= cfg_data[0];
        REG_CRC_WIDTH:     crc_width     <= cfg_data[WIDTH_W-1:0];
        REG_POLYNOMIAL:    polynomial    <= cfg_data[CRC_W-1:0];
        REG_INITIAL_VALUE: initial_value <= cfg_data[CRC_W-1:0];
        default: ;
      endcase
    end
  end

  // In normal order the polynomial is left-aligned to the top bit of the register.
  assign align_shift = MAX_CRC_WIDTH - crc_width;

  always_comb begin
    cfg.reflected     = reflected;
    cfg.polynomial    = polynomial;
    cfg.poly_aligned  = polynomial << align_shift;
    cfg.initial_value = initial_value;
    cfg.bad           = (crc_width < MIN_CRC_WIDTH) || (crc_width > MAX_CRC_WIDTH) ||
                        ((polynomial >> crc_width) != '0);
  end
endmodule

// ----- sv/ctc_crc_core.sv -----
module ctc_crc_core (
  input  logic                           clk,
  input  logic                           rst,
  input  ctc_pkg::ctc_cfg_t              cfg,
  input  logic                           update,
  input  logic [ctc_pkg::DATA_W-1:0]     data_byte,
  input  logic                           first_byte,
  output logic [ctc_pkg::CRC_W-1:0]      crc_register,
  output logic [ctc_pkg::CRC_W-1:0]      crc_next
);
  import ctc_pkg::*;

  logic [CRC_W-1:0]  crc_start;
  logic [DATA_W-1:0] idx;
  logic [CRC_W-1:0]  term_refl;
  logic [CRC_W-1:0]  term_norm;
  logic [CRC_W-1:0]  term;

  assign crc_start = first_byte ? cfg.initial_value : crc_register;
  assign idx       = crc_start[DATA_W-1:0] ^ data_byte;

  // Eight LFSR steps on one byte, one unrolled chain for each bit order.
  always_comb begin
    term_refl = {{(CRC_W-DATA_W){1'b0}}, idx};
    term_norm = {idx, {(CRC_W-DATA_W){1'b0}}};
    for (int k = 0; k < DATA_W; k++) begin
      term_refl = (term_refl >> 1) ^ (cfg.polynomial & {CRC_W{term_refl[0]}});
      term_norm = (term_norm << 1) ^ (cfg.poly_aligned & {CRC_W{term_norm[CRC_W-1]}});
    end
  end

  // The normal-order register is held byte-swapped.
  assign term = cfg.reflected ? term_refl :
                {term_norm[7:0], term_norm[15:8], term_norm[23:16], term_norm[31:24]};

  assign crc_next = cfg.bad ? crc_register : (term ^ (crc_start >> DATA_W));

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_register <= '0;
    end else if (update) begin
      crc_register <= crc_next;
    end
  end
endmodule
